/* rtl/line_program_row_encoder_macros.svh */
// Assertion macros used by the line program row encoder controller.
`ifndef LINE_PROGRAM_ROW_ENCODER_MACROS_SVH
`define LINE_PROGRAM_ROW_ENCODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LPRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpre: implication check failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LPRE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpre: next-cycle check failed");
`else
`define LPRE_ASSERT_IMP(lbl, ante, cons)
`define LPRE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/lpre_pkg.sv */
// Shared types and constants of the line program row encoder.
package lpre_pkg;

    localparam int LD_W      = 32;  // line delta
    localparam int AD_W      = 31;  // address delta
    localparam int CFG_W     = 8;   // every config register
    localparam int CFG_IDX_W = 8;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 8;
    localparam int DIV_STEPS = 16;  // two quotient bits per step
    localparam int DIV_CNT_W = 4;

    localparam logic [7:0] OP_COPY       = 8'd1;
    localparam logic [7:0] OP_ADVANCE_PC = 8'd2;
    localparam logic [7:0] OP_ADVANCE_LN = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BASE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RANGE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_BASE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 8'd3;

    localparam logic [CFG_W-1:0] RST_LINE_BASE   = 8'hFB;  // -5
    localparam logic [CFG_W-1:0] RST_LINE_RANGE  = 8'd14;
    localparam logic [CFG_W-1:0] RST_OPCODE_BASE = 8'd13;
    localparam logic [CFG_W-1:0] RST_MIN_LEN     = 8'd1;

    typedef enum logic [2:0] {
        SEL_SPECIAL,
        SEL_OP_LN,
        SEL_SLEB,
        SEL_OP_PC,
        SEL_ULEB,
        SEL_COPY
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      mul;
        logic      emit;
        t_emit_sel sel;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic special;
        logic dl_zero;
        logic addr_zero;
        logic sleb_more;
        logic uleb_more;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/line_program_row_encoder.sv */
// Top level of the line program row encoder: ports, controller and datapath.
//
//  Port group   Dir  Payload (lowest bit first)
//  s_*          in   tdata: line_delta[31:0], address_delta[62:32], zero pad [63]
//  m_*          out  tdata: out_byte[7:0]; tlast: last_byte
//  cfg_*        in   index 0 line_base, 1 line_range, 2 opcode_base, 3 min_inst_length
//
// One row at a time: accept, divide by min_inst_length at two quotient bits per
// cycle, multiply, window check, then one byte per cycle while the output does
// not stall, 1 to 13 bytes per row.
// The last byte of a row sits in the output register while the next row is taken.
// Output stalls hold the byte builder; synchronous active-low reset restores the
// default config, current line 1 and current address 0.
module line_program_row_encoder
    import lpre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,    // line_delta, address_delta, pad
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,    // out_byte
    output logic                 o_m_tlast,    // last_byte
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    lpre_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_status  (status),
        .o_s_ready (o_s_tready),
        .o_cmd     (cmd)
    );

    lpre_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_line_delta    (i_s_tdata[LD_W-1:0]),
        .i_address_delta (i_s_tdata[LD_W+AD_W-1:LD_W]),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_m_ready       (i_m_tready),
        .o_m_valid       (o_m_tvalid),
        .o_m_byte        (o_m_tdata),
        .o_m_last        (o_m_tlast)
    );

endmodule

/* rtl/lpre_ctrl.sv */
// Controller state machine of the line program row encoder.
`include "line_program_row_encoder_macros.svh"

module lpre_ctrl
    import lpre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  t_dp_status i_status,
    output logic       o_s_ready,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CHK,
        ST_SPECIAL,
        ST_LN_OP,
        ST_LN_DATA,
        ST_PC_OP,
        ST_PC_DATA,
        ST_COPY
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.sel = SEL_COPY;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                if (i_status.special) begin
                    n_state = ST_SPECIAL;
                end else if (!i_status.dl_zero) begin
                    n_state = ST_LN_OP;
                end else if (!i_status.addr_zero) begin
                    n_state = ST_PC_OP;
                end else begin
                    n_state = ST_COPY;
                end
            end
            ST_SPECIAL: begin
                o_cmd.sel = SEL_SPECIAL;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_LN_OP: begin
                o_cmd.sel = SEL_OP_LN;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_LN_DATA;
                end
            end
            ST_LN_DATA: begin
                o_cmd.sel = SEL_SLEB;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.sleb_more) begin
                        n_state = i_status.addr_zero ? ST_COPY : ST_PC_OP;
                    end
                end
            end
            ST_PC_OP: begin
                o_cmd.sel = SEL_OP_PC;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_PC_DATA;
                end
            end
            ST_PC_DATA: begin
                o_cmd.sel = SEL_ULEB;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.uleb_more) begin
                        n_state = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.sel = SEL_COPY;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LPRE_ASSERT_NXT(a_accept_to_div, o_s_ready && i_s_valid, r_state == ST_DIV)
    `LPRE_ASSERT_IMP(a_emit_needs_room, o_cmd.emit, i_status.out_free)
    `LPRE_ASSERT_NXT(a_div_to_mul, r_state == ST_DIV && i_status.div_done, r_state == ST_MUL)
    `LPRE_ASSERT_NXT(a_copy_ends_row, r_state == ST_COPY && o_cmd.emit, r_state == ST_IDLE)

endmodule

/* rtl/lpre_dp.sv */
// Datapath of the line program row encoder: config, divider, opcode check, byte builder.
module lpre_dp
    import lpre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [LD_W-1:0]      i_line_delta,
    input  logic [AD_W-1:0]      i_address_delta,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_m_ready,
    output logic                 o_m_valid,
    output logic [7:0]           o_m_byte,
    output logic                 o_m_last
);

    logic [CFG_W-1:0]     r_line_base;
    logic [CFG_W-1:0]     r_line_range;
    logic [CFG_W-1:0]     r_opcode_base;
    logic [CFG_W-1:0]     r_min_len;

    logic [LD_W-1:0]      r_cur_line;
    logic [31:0]          r_cur_addr;

    logic [LD_W:0]        r_d;        // line_delta - line_base, 33-bit two's complement
    logic signed [LD_W-1:0] r_sv;     // SLEB128 shifter
    logic [AD_W-1:0]      r_uv;       // ULEB128 shifter
    logic [AD_W-1:0]      r_addr;
    logic                 r_dl_zero;
    logic                 r_addr_zero;
    logic [CFG_W-1:0]     r_div;
    logic [AD_W:0]        r_quo;
    logic [CFG_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [AD_W+CFG_W-1:0] r_prod;

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_last;

    // two restoring divide steps per cycle
    logic [CFG_W:0]       t1, rm1, t2, rm2;
    logic                 ge1, ge2;
    logic [AD_W+CFG_W:0]  opc_sum;
    logic signed [LD_W-1:0] sv_shift;
    logic                 sleb_more;
    logic                 uleb_more;
    logic                 out_free;
    logic [7:0]           n_byte;
    logic                 n_last;

    always_comb begin
        t1  = {r_rem, r_quo[AD_W]};
        ge1 = (t1 >= {1'b0, r_div});
        rm1 = ge1 ? (t1 - {1'b0, r_div}) : t1;
        t2  = {rm1[CFG_W-1:0], r_quo[AD_W-1]};
        ge2 = (t2 >= {1'b0, r_div});
        rm2 = ge2 ? (t2 - {1'b0, r_div}) : t2;
    end

    assign opc_sum = (AD_W+CFG_W+1)'(r_d[7:0]) + (AD_W+CFG_W+1)'(r_prod)
                   + (AD_W+CFG_W+1)'(r_opcode_base);

    assign sv_shift  = r_sv >>> 7;
    assign sleb_more = !(((sv_shift == '0) && !r_sv[6]) || ((sv_shift == '1) && r_sv[6]));
    assign uleb_more = |r_uv[AD_W-1:7];
    assign out_free  = !r_valid || i_m_ready;

    always_comb begin
        o_status.div_done  = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        // line delta in window, then opcode must not pass 255
        o_status.special   = !r_d[LD_W] && (r_d < (LD_W+1)'(r_line_range))
                           && (opc_sum <= (AD_W+CFG_W+1)'(255));
        o_status.dl_zero   = r_dl_zero;
        o_status.addr_zero = r_addr_zero;
        o_status.sleb_more = sleb_more;
        o_status.uleb_more = uleb_more;
        o_status.out_free  = out_free;
    end

    always_comb begin
        n_byte = OP_COPY;
        n_last = 1'b0;
        case (i_cmd.sel)
            SEL_SPECIAL: begin
                n_byte = opc_sum[7:0];
                n_last = 1'b1;
            end
            SEL_OP_LN: n_byte = OP_ADVANCE_LN;
            SEL_SLEB:  n_byte = {sleb_more, r_sv[6:0]};
            SEL_OP_PC: n_byte = OP_ADVANCE_PC;
            SEL_ULEB:  n_byte = {uleb_more, r_uv[6:0]};
            SEL_COPY: begin
                n_byte = OP_COPY;
                n_last = 1'b1;
            end
            default: begin
                n_byte = OP_COPY;
                n_last = 1'b1;
            end
        endcase
    end

    // config registers and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_base   <= RST_LINE_BASE;
            r_line_range  <= RST_LINE_RANGE;
            r_opcode_base <= RST_OPCODE_BASE;
            r_min_len     <= RST_MIN_LEN;
            r_cur_line    <= 32'd1;
            r_cur_addr    <= 32'd0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LINE_BASE:   r_line_base   <= i_cfg_data;
                    CFG_LINE_RANGE:  r_line_range  <= i_cfg_data;
                    CFG_OPCODE_BASE: r_opcode_base <= i_cfg_data;
                    CFG_MIN_LEN:     r_min_len     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_cur_line <= r_cur_line + i_line_delta;
                r_cnt      <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            // advance by the aligned part of the address delta
            if (i_cmd.mul) begin
                r_cur_addr <= r_cur_addr + (32'(r_addr) - 32'(r_rem));
            end
        end
    end

    // item payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d         <= {i_line_delta[LD_W-1], i_line_delta}
                         - {{(LD_W+1-CFG_W){r_line_base[CFG_W-1]}}, r_line_base};
            r_sv        <= signed'(i_line_delta);
            r_addr      <= i_address_delta;
            r_dl_zero   <= (i_line_delta == '0);
            r_addr_zero <= (i_address_delta == '0);
            r_div       <= (r_min_len == '0) ? CFG_W'(1) : r_min_len;
            r_quo       <= {1'b0, i_address_delta};
            r_rem       <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[AD_W-2:0], ge1, ge2};
            r_rem <= rm2[CFG_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= (AD_W+CFG_W)'(r_line_range) * (AD_W+CFG_W)'(r_quo[AD_W-1:0]);
            r_uv   <= r_quo[AD_W-1:0];
        end
        if (i_cmd.emit && (i_cmd.sel == SEL_SLEB)) begin
            r_sv <= sv_shift;
        end
        if (i_cmd.emit && (i_cmd.sel == SEL_ULEB)) begin
            r_uv <= r_uv >> 7;
        end
    end

    // output register: free when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_m_valid = r_valid;
    assign o_m_byte  = r_byte;
    assign o_m_last  = r_last;

endmodule

/* tb/sv/tb_line_program_row_encoder.sv */
// Self-checking testbench for the line program row encoder: directed rows, random rows, config sweeps.
`timescale 1ns / 1ps

module tb_line_program_row_encoder;
    import lpre_pkg::*;

    // Predicts the byte stream of each row and checks the bytes that the block delivers.
    // Each queued entry holds {last_byte, out_byte}.
    class row_byte_scoreboard;
        logic signed [7:0] line_base;
        logic [7:0]        line_range;
        logic [7:0]        opcode_base;
        logic [7:0]        min_len;
        logic [31:0]       cur_line;
        logic [31:0]       cur_addr;
        logic [8:0]        pending_bytes[$];
        int                n_fail;
        int                n_rows;
        int                n_bytes;
        int                n_special;

        function new();
            line_base   = RST_LINE_BASE;
            line_range  = RST_LINE_RANGE;
            opcode_base = RST_OPCODE_BASE;
            min_len     = RST_MIN_LEN;
            cur_line    = 32'd1;
            cur_addr    = 32'd0;
            n_fail      = 0;
            n_rows      = 0;
            n_bytes     = 0;
            n_special   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_LINE_BASE:   line_base   = val;
                CFG_LINE_RANGE:  line_range  = val;
                CFG_OPCODE_BASE: opcode_base = val;
                CFG_MIN_LEN:     min_len     = val;
                default: ;  // out-of-range index: the block drops the write
            endcase
        endfunction

        // Work out the bytes of one accepted row and queue them.
        function void note_row(logic signed [31:0] dl, logic [30:0] ad);
            longint          lb;
            longint          d;
            longint          opc;
            longint          s;
            longint unsigned div;
            longint unsigned opadv;
            longint unsigned u;
            logic [7:0]      b;
            logic [8:0]      tail;
            bit              more;

            div   = (min_len == 8'd0) ? 64'd1 : {56'd0, min_len};
            opadv = {33'd0, ad} / div;
            lb    = line_base;
            d     = dl;
            opc   = (d - lb) + longint'(line_range) * longint'(opadv) + longint'(opcode_base);

            if (opc >= 0 && opc <= 255 && d >= lb && (d - lb) < longint'(line_range)) begin
                pending_bytes.push_back({1'b0, opc[7:0]});
                n_special++;
            end else begin
                if (d != 0) begin
                    pending_bytes.push_back({1'b0, OP_ADVANCE_LN});
                    s = d;
                    do begin
                        b = {1'b0, s[6:0]};
                        s = s >>> 7;
                        more = !((s == 0 && !b[6]) || (s == -1 && b[6]));
                        if (more) b[7] = 1'b1;
                        pending_bytes.push_back({1'b0, b});
                    end while (more);
                end
                if (ad != 0) begin
                    pending_bytes.push_back({1'b0, OP_ADVANCE_PC});
                    u = opadv;
                    do begin
                        b = {1'b0, u[6:0]};
                        u = u >> 7;
                        if (u != 0) b[7] = 1'b1;
                        pending_bytes.push_back({1'b0, b});
                    end while (u != 0);
                end
                pending_bytes.push_back({1'b0, OP_COPY});
            end

            // flag the closing byte of the row
            tail = pending_bytes.pop_back();
            tail[8] = 1'b1;
            pending_bytes.push_back(tail);

            cur_line = cur_line + dl;
            cur_addr = cur_addr + opadv[31:0] * div[31:0];
            n_rows++;
        endfunction

        // Compare one delivered byte with the oldest queued one.
        function void check_byte(logic [7:0] b, logic last);
            logic [8:0] want;

            n_bytes++;
            if (pending_bytes.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("ERROR: byte 0x%02h (last %b) delivered with no row pending", b, last);
            end else begin
                want = pending_bytes.pop_front();
                if (b !== want[7:0] || last !== want[8]) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("ERROR: byte %0d: out_byte 0x%02h last %b, wanted 0x%02h last %b",
                                 n_bytes, b, last, want[7:0], want[8]);
                end
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;   // line_delta[31:0], address_delta[62:32], pad[63]
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;          // out_byte[7:0]
    logic                 o_m_tlast;          // last_byte
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Idle percentages for the current phase: sender gaps and receiver stalls.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int n_phases = 0;

    row_byte_scoreboard sb;

    line_program_row_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: stall at random with the phase's percentage.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Output monitor: every accepted byte goes to the scoreboard. Values read here are
    // the ones that stood before this edge, the same ones the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_byte(o_m_tdata, o_m_tlast);
    end

    // Offer one row; hold tvalid across back-to-back rows, drop it only for a gap.
    task automatic send_row(input logic signed [31:0] dl, input logic [30:0] ad);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, ad, dl};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_row(dl, ad);
    endtask

    // Stop offering rows until every queued byte is out, then let the pipe settle.
    task automatic drain_rows(input int settle);
        i_s_tvalid <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write all four registers in consecutive cycles, then one write to an unused index.
    task automatic program_regs(input logic [7:0] lb, input logic [7:0] lr,
                                input logic [7:0] ob, input logic [7:0] ml);
        logic [CFG_IDX_W-1:0] idx[5];
        logic [CFG_W-1:0]     val[5];

        idx = '{CFG_LINE_BASE, CFG_LINE_RANGE, CFG_OPCODE_BASE, CFG_MIN_LEN,
                CFG_IDX_W'($urandom_range(4, 255))};
        val = '{lb, lr, ob, ml, CFG_W'($urandom)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
        n_phases++;
    endtask

    // Pick a random row: mostly rows a compiler would emit under the current settings
    // (line step inside the window, small address step), the rest wide and odd values.
    task automatic random_row(output logic signed [31:0] dl, output logic [30:0] ad);
        int unsigned div;
        int unsigned opadv;

        div = (sb.min_len == 8'd0) ? 1 : sb.min_len;
        if (sb.line_range != 8'd0 && $urandom_range(99) < 60) begin
            dl    = int'(sb.line_base) + int'($urandom_range(int'(sb.line_range) - 1));
            opadv = $urandom_range(255 / int'(sb.line_range) + 1);
            ad    = 31'(opadv * div + $urandom_range(div - 1));
        end else begin
            case ($urandom_range(3))
                0: dl = int'($urandom_range(400)) - 200;
                1: dl = 32'sd0;
                2: dl = $urandom;
                default: begin
                    dl = 32'sd1 <<< $urandom_range(31);
                    if ($urandom_range(1)) dl = dl - 1;
                    if ($urandom_range(1)) dl = -dl;
                end
            endcase
            case ($urandom_range(3))
                0: ad = '0;
                1: ad = 31'($urandom_range(300));
                2: ad = 31'($urandom);
                default: begin
                    ad = 31'd1 << $urandom_range(30);
                    if ($urandom_range(1)) ad = ad - 31'd1;
                end
            endcase
        end
    endtask

    // One random phase: settings, idle mode, row count; odd phases pause halfway
    // until the block has delivered everything.
    task automatic random_phase(input logic [7:0] lb, input logic [7:0] lr,
                                input logic [7:0] ob, input logic [7:0] ml,
                                input int mode, input int n_rows, input bit pause_mid);
        logic signed [31:0] dl;
        logic [30:0]        ad;

        drain_rows(40);
        program_regs(lb, lr, ob, ml);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
            default: begin src_idle_pct = 19; snk_stall_pct = 19; end
        endcase
        for (int k = 0; k < n_rows; k++) begin
            if (pause_mid && k == n_rows / 2) drain_rows(0);
            random_row(dl, ad);
            send_row(dl, ad);
        end
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("ERROR: timeout with %0d bytes still pending", sb.pending_bytes.size());
        $display("** line_program_row_encoder: FAILED **");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset settings (base -5, range 14, opcode base 13, length 1).
        send_row(32'sd0, 31'd0);                // special, middle of the window
        send_row(-32'sd5, 31'd0);               // lowest line step of the window
        send_row(32'sd8, 31'd0);                // highest line step of the window
        send_row(32'sd9, 31'd0);                // just above the window: general form
        send_row(-32'sd6, 31'd0);               // just below the window
        send_row(32'sd8, 31'd16);               // special opcode 250
        send_row(32'sd0, 31'd17);               // opcode 256: general form, line skipped
        send_row(-32'sd5, 31'd17);              // special opcode 251
        send_row(32'sd63, 31'd127);             // one-byte signed and unsigned operands
        send_row(32'sd64, 31'd128);             // two-byte operands
        send_row(-32'sd64, 31'd0);
        send_row(-32'sd65, 31'd0);
        send_row(32'h7FFF_FFFF, 31'h7FFF_FFFF); // widest fields
        send_row(32'h8000_0000, 31'h7FFF_FFFF); // longest row: thirteen bytes
        send_row(-32'sd1, 31'h4000_0000);

        // Zero range and zero length: no special opcode, divisor taken as one.
        drain_rows(40);
        program_regs(8'h00, 8'd0, 8'd255, 8'd0);
        send_row(32'sd0, 31'd0);                // both steps zero: copy alone
        send_row(32'sd3, 31'd5);
        send_row(32'sd0, 31'd9);

        // Length 4: unaligned address steps lose their remainder.
        drain_rows(40);
        program_regs(8'hFD, 8'd12, 8'd10, 8'd4);
        send_row(32'sd1, 31'd7);                // special with one operation step
        send_row(32'sd1, 31'd3);                // operation step zero: special
        send_row(32'sd20, 31'd3);               // general form with advance_pc of zero
        send_row(32'sd20, 31'd0);
        send_row(-32'sd3, 31'd1027);

        // Random phases: typical settings, the extremes, then random settings.
        random_phase(8'hFB, 8'd14,  8'd13,  8'd1,   0, 44, 1'b0);
        random_phase(8'h80, 8'd255, 8'd255, 8'd255, 1, 44, 1'b1);
        random_phase(8'h7F, 8'd0,   8'd1,   8'd0,   2, 44, 1'b0);
        random_phase(8'h00, 8'd1,   8'd1,   8'd1,   3, 44, 1'b1);
        for (int p = 0; p < 4; p++) begin
            random_phase(8'($urandom), 8'($urandom_range(1, 20)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(0, 8)), p, 44, p[0]);
        end

        // Close: drain, settle, report.
        drain_rows(40);
        $display("Covered %0d rows (%0d as special opcodes), %0d bytes, %0d register settings,",
                 sb.n_rows, sb.n_special, sb.n_bytes, n_phases);
        $display("with idle-free, sender-gap, receiver-stall and mixed back-pressure phases.");
        if (sb.n_fail == 0 && sb.pending_bytes.size() == 0) begin
            $display("** line_program_row_encoder: PASSED **");
        end else begin
            $display("%0d mismatches, %0d bytes never delivered", sb.n_fail,
                     sb.pending_bytes.size());
            $display("** line_program_row_encoder: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lpre_pkg.sv
rtl/lpre_ctrl.sv
rtl/lpre_dp.sv
rtl/line_program_row_encoder.sv
tb/sv/tb_line_program_row_encoder.sv
